### sv/cmr_pkg.sv
`default_nettype none

package cmr_pkg;

  // Fixed field layout of the input and output items
  localparam int FIELD_ROW_W   = 24;
  localparam int BIAS_W        = 8;
  localparam int PARTIAL_W     = 32;
  localparam int RESULT_W      = 32;
  localparam int SHIFT_W       = 5;
  localparam int CFG_DATA_W    = 5;
  localparam int CFG_INDEX_W   = 1;

  localparam int ROWS          = 3;
  localparam int TAPS_PER_ROW  = 3;
  localparam int NUM_TAPS      = ROWS * TAPS_PER_ROW;

  localparam int PIX_ROW0_LSB  = 0;
  localparam int WGT_ROW0_LSB  = ROWS * FIELD_ROW_W;
  localparam int BIAS_LSB      = 2 * ROWS * FIELD_ROW_W;
  localparam int PARTIAL_LSB   = BIAS_LSB + BIAS_W;
  localparam int S_TDATA_W     = PARTIAL_LSB + PARTIAL_W;

  localparam int USER_USE_BIAS    = 0;
  localparam int USER_USE_PARTIAL = 1;
  localparam int USER_RELU        = 2;
  localparam int S_TUSER_W        = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIAS_SHIFT  = 1'b1;

  // Per-item control carried alongside the datapath
  typedef struct packed {
    logic last;
    logic relu;
  } cmr_ctrl_t;

endpackage

`default_nettype wire

### sv/cmr_lane.sv
`default_nettype none

module cmr_lane #(
  parameter int DATA_W   = 8,
  parameter int WEIGHT_W = 8
) (
  input  wire logic                               clk,
  input  wire logic                               en,
  input  wire logic                               tap_on,
  input  wire logic signed [DATA_W-1:0]           pixel,
  input  wire logic signed [WEIGHT_W-1:0]         weight,
  output logic signed [DATA_W+WEIGHT_W-1:0]       product
);

  logic signed [DATA_W+WEIGHT_W-1:0] product_next;

  assign product_next = pixel * weight;

  always_ff @(posedge clk) begin
    if (en) begin
      product <= tap_on ? product_next : '0;
    end
  end

endmodule

`default_nettype wire

### sv/cmr_tree.sv
`default_nettype none

module cmr_tree #(
  parameter int PROD_W = 16,
  parameter int MACC_W = 20
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [PROD_W-1:0] product [cmr_pkg::NUM_TAPS],
  output logic signed [MACC_W-1:0]      chan_sum
);

  logic [MACC_W-1:0] sum_next;

  // Sum wraps at MACC_W: adding each product truncated or sign-extended gives the same bits
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < cmr_pkg::NUM_TAPS; i++) begin
      sum_next = sum_next + MACC_W'(product[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chan_sum <= sum_next;
    end
  end

endmodule

`default_nettype wire

### sv/conv_mac_adder_tree_relu_top.sv
// Convolution processing element with nine multiplier lanes and an adder tree.
// Input stream (s_*): one transaction per input channel, carrying a 3x3 pixel
// window, its weights, and the group controls (bias, partial sum, enables).
// Only the controls of the transaction that completes a group of CHANNELS
// transactions are used. Output stream (m_*): one result per group.
// Configuration: cfg_wr_en/cfg_index/cfg_data write kernel_mode (index 0) and
// bias_shift (index 1); write only while the block is idle.
// Throughput: one input transaction per cycle while s_tready is high. The path
// is three register stages: multiplier lanes, adder tree, then accumulator and
// final add into the output register, whose valid flag drives m_tvalid once
// the last transaction of a group reaches it.
// A stalled output holds its result; stages behind it keep filling until
// occupied, then s_tready drops. Every stage holds while the next is stalled.
// Reset (rst, synchronous) clears the channel counter, accumulator, valid
// flags and both configuration registers; no clearing sweep follows.
`default_nettype none

module conv_mac_adder_tree_relu_top #(
  parameter int CHANNELS = 32,
  parameter int DATA_W   = 8,
  parameter int WEIGHT_W = 8,
  parameter int MACC_W   = 20,
  parameter int OUT_W    = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // pixels_row0, pixels_row1, pixels_row2, weights_row0, weights_row1,
  // weights_row2, bias, partial_sum
  input  wire logic [cmr_pkg::S_TDATA_W-1:0]       s_tdata,
  // use_bias, use_partial, relu
  input  wire logic [cmr_pkg::S_TUSER_W-1:0]       s_tuser,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // result
  output logic [cmr_pkg::RESULT_W-1:0]             m_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  input  wire logic                                cfg_wr_en,
  input  wire logic [cmr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [cmr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PROD_W = DATA_W + WEIGHT_W;
  localparam int CNT_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PIX_WIDE_W = 3 * DATA_W + cmr_pkg::FIELD_ROW_W;
  localparam int WGT_WIDE_W = 3 * WEIGHT_W + cmr_pkg::FIELD_ROW_W;

  // Configuration
  logic                              kernel_mode;
  logic [cmr_pkg::SHIFT_W-1:0]       bias_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_mode <= 1'b0;
      bias_shift  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cmr_pkg::REG_KERNEL_MODE: kernel_mode <= cfg_data[0];
        cmr_pkg::REG_BIAS_SHIFT:  bias_shift  <= cfg_data[cmr_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: each stage loads when empty or when the stage after it moves
  logic v1, v2, out_valid;
  logic ready1, ready2, ready3;
  logic accept;

  assign ready3   = !out_valid || m_tready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign s_tready = ready1;
  assign accept   = s_tvalid && ready1;

  // Channel counter
  logic [CNT_W-1:0] cnt;
  logic             last_in;

  assign last_in = (cnt == CNT_W'(CHANNELS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (accept) begin
      cnt <= last_in ? '0 : cnt + 1'b1;
    end
  end

  // Operand extraction, zero-filled above the field for wide lane settings
  logic signed [PROD_W-1:0] product [cmr_pkg::NUM_TAPS];

  genvar r, k;
  generate
    for (r = 0; r < cmr_pkg::ROWS; r++) begin : g_row
      logic [PIX_WIDE_W-1:0] pix_wide;
      logic [WGT_WIDE_W-1:0] wgt_wide;

      assign pix_wide = {{(3 * DATA_W){1'b0}},
                         s_tdata[cmr_pkg::PIX_ROW0_LSB + r * cmr_pkg::FIELD_ROW_W +:
                                 cmr_pkg::FIELD_ROW_W]};
      assign wgt_wide = {{(3 * WEIGHT_W){1'b0}},
                         s_tdata[cmr_pkg::WGT_ROW0_LSB + r * cmr_pkg::FIELD_ROW_W +:
                                 cmr_pkg::FIELD_ROW_W]};

      for (k = 0; k < cmr_pkg::TAPS_PER_ROW; k++) begin : g_tap
        cmr_lane #(
          .DATA_W   (DATA_W),
          .WEIGHT_W (WEIGHT_W)
        ) u_lane (
          .clk     (clk),
          .en      (ready1),
          .tap_on  (!kernel_mode || (r == 0 && k == 0)),
          .pixel   ($signed(pix_wide[k * DATA_W +: DATA_W])),
          .weight  ($signed(wgt_wide[k * WEIGHT_W +: WEIGHT_W])),
          .product (product[r * cmr_pkg::TAPS_PER_ROW + k])
        );
      end
    end
  endgenerate

  // Bias scaling and partial sum, folded into one term at the input
  logic signed [cmr_pkg::BIAS_W-1:0]  bias_in;
  logic signed [MACC_W-1:0]           bias_wide;
  logic signed [MACC_W-1:0]           bias_shifted;
  logic [cmr_pkg::SHIFT_W:0]          rsh;
  logic [OUT_W-1:0]                   bias_term;
  logic [OUT_W-1:0]                   partial_term;
  logic [OUT_W-1:0]                   extra_next;

  assign bias_in   = $signed(s_tdata[cmr_pkg::BIAS_LSB +: cmr_pkg::BIAS_W]);
  assign bias_wide = MACC_W'(bias_in);
  assign rsh       = '0 - {bias_shift[cmr_pkg::SHIFT_W-1], bias_shift};

  always_comb begin
    if (!bias_shift[cmr_pkg::SHIFT_W-1] && (bias_shift != '0)) begin
      bias_shifted = bias_wide << bias_shift[cmr_pkg::SHIFT_W-2:0];
    end else begin
      bias_shifted = bias_wide >>> rsh;
    end
  end

  assign bias_term    = s_tuser[cmr_pkg::USER_USE_BIAS] ? OUT_W'(bias_shifted) : '0;
  assign partial_term = s_tuser[cmr_pkg::USER_USE_PARTIAL] ?
                        OUT_W'($signed(s_tdata[cmr_pkg::PARTIAL_LSB +: cmr_pkg::PARTIAL_W])) :
                        '0;
  assign extra_next   = bias_term + partial_term;

  // Stage 1: lane products
  cmr_pkg::cmr_ctrl_t ctrl1, ctrl2;
  logic [OUT_W-1:0]   extra1, extra2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      ctrl1.last <= last_in;
      ctrl1.relu <= s_tuser[cmr_pkg::USER_RELU];
      extra1     <= extra_next;
    end
  end

  // Stage 2: adder tree
  logic signed [MACC_W-1:0] chan_sum;

  cmr_tree #(
    .PROD_W (PROD_W),
    .MACC_W (MACC_W)
  ) u_tree (
    .clk      (clk),
    .en       (ready2),
    .product  (product),
    .chan_sum (chan_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      ctrl2  <= ctrl1;
      extra2 <= extra1;
    end
  end

  // Stage 3: accumulate, finish the group into the output register
  logic [OUT_W-1:0]                 acc;
  logic [OUT_W-1:0]                 total;
  logic [OUT_W-1:0]                 final_sum;
  logic [cmr_pkg::RESULT_W-1:0]     result_next;
  logic [cmr_pkg::RESULT_W-1:0]     result;
  logic                             advance3;

  assign advance3    = v2 && ready3;
  assign total       = acc + OUT_W'(chan_sum);
  assign final_sum   = total + extra2;
  assign result_next = (ctrl2.relu && final_sum[OUT_W-1]) ? '0 :
                       cmr_pkg::RESULT_W'($signed(final_sum));

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance3) begin
        acc <= ctrl2.last ? '0 : total;
      end
      if (ready3) begin
        out_valid <= v2 && ctrl2.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance3 && ctrl2.last) begin
      result <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = result;

endmodule

`default_nettype wire
